// ===== hdl/shared_exclusive_lock_table_assert.svh =====
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_ASSERT_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SELT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SELT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/selt_pkg.sv =====
package selt_pkg;

  localparam int LOCAL_RESOURCES_DEF      = 32;
  localparam int HOLDERS_PER_RESOURCE_DEF = 8;
  localparam int QUEUE_DEPTH_DEF          = 8;
  localparam int TRANS_ID_BITS_DEF        = 16;

  localparam logic [1:0] ACT_ACQUIRE     = 2'd0;
  localparam logic [1:0] ACT_RELEASE     = 2'd1;
  localparam logic [1:0] ACT_RELEASE_ALL = 2'd2;
  localparam logic [1:0] ACT_WITHDRAW    = 2'd3;

  localparam logic [3:0] ST_GRANTED     = 4'd0;
  localparam logic [3:0] ST_BLOCKED     = 4'd1;
  localparam logic [3:0] ST_NOT_LOCAL   = 4'd2;
  localparam logic [3:0] ST_RELEASED    = 4'd3;
  localparam logic [3:0] ST_NOT_HOLDER  = 4'd4;
  localparam logic [3:0] ST_WITHDRAWN   = 4'd5;
  localparam logic [3:0] ST_NOT_WAITING = 4'd6;
  localparam logic [3:0] ST_HOLD_FULL   = 4'd7;
  localparam logic [3:0] ST_QUEUE_FULL  = 4'd8;
  localparam logic [3:0] ST_DONE        = 4'd9;

  localparam logic CFG_NODE_ID      = 1'b0;
  localparam logic CFG_RES_PER_NODE = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] trans_id;
    logic [15:0] res_id;
    logic        lock_mode;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] res_id_out;
    logic        notify_valid;
    logic [15:0] notify_trans;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  node_id;
    logic [5:0]  rpn;
    logic [15:0] base;
  } cfg_t;

endpackage

// ===== hdl/selt_chan_if.sv =====
interface selt_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/selt_ram.sv =====
module selt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hdl/selt_engine.sv =====
module selt_engine #(
  parameter int LR = selt_pkg::LOCAL_RESOURCES_DEF,
  parameter int HP = selt_pkg::HOLDERS_PER_RESOURCE_DEF,
  parameter int QD = selt_pkg::QUEUE_DEPTH_DEF,
  parameter int TB = selt_pkg::TRANS_ID_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  selt_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  selt_pkg::req_t  in_data,
  output logic            o_valid,
  input  logic            o_ready,
  output selt_pkg::rsp_t  o_data
);
  localparam int RW  = (LR > 1) ? $clog2(LR) : 1;
  localparam int SW  = (HP > 1) ? $clog2(HP) : 1;
  localparam int SCW = $clog2(HP + 1);
  localparam int QW  = $clog2(QD + 1);
  localparam int HD  = LR * HP;
  localparam int QDP = LR * QD;
  localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
  localparam int QAW = (QDP > 1) ? $clog2(QDP) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_ACQ, S_SCAN, S_APPLY, S_WD, S_EMIT, S_NEXT
  } state_t;

  state_t          st;
  logic [1:0]      act;
  logic [TB-1:0]   t;
  logic            mode;
  logic [RW-1:0]   r;
  logic [SCW-1:0]  sc;
  logic            pend;
  logic [SW-1:0]   ps;
  logic            found;
  logic [SW-1:0]   fslot;
  logic [QW-1:0]   qi;
  logic [QW-1:0]   qn;
  logic            qpend;
  logic            wfound;
  logic [3:0]      e_status;
  logic [15:0]     e_res;
  logic            e_nv;
  logic            e_last;
  logic [HP-1:0]   hv [LR];
  logic [HP-1:0]   hm [LR];
  logic [QW-1:0]   qc [LR];

  logic [15:0]     d;
  logic            loc;
  logic [RW-1:0]   r_in;
  logic [TB-1:0]   t_in;
  logic [TB-1:0]   h_rdata;
  logic [TB-1:0]   q_rdata;
  logic            hit;
  logic            h_re;
  logic            h_we;
  logic [HAW-1:0]  h_raddr;
  logic [HAW-1:0]  h_waddr;
  logic            has_free;
  logic [SW-1:0]   free_s;
  logic [SW-1:0]   slot_w;
  logic            any_h;
  logic            any_x;
  logic [QW-1:0]   qcur;
  logic            conflict;
  logic            q_we;
  logic            q_re;
  logic [QAW-1:0]  q_waddr;
  logic [QAW-1:0]  q_raddr;
  logic [QAW-1:0]  qbase;
  logic [TB-1:0]   q_wdata;

  always_comb begin
    d    = in_data.res_id - cfg.base;
    loc  = (in_data.res_id != 16'd0) && (cfg.node_id != 8'd0) && (cfg.rpn != 6'd0) &&
           (in_data.res_id >= cfg.base) && (d < 16'(cfg.rpn)) && (d < 16'(LR));
    r_in = d[RW-1:0];
    t_in = TB'(in_data.trans_id);
  end

  always_comb begin
    any_h    = |hv[r];
    any_x    = |(hv[r] & hm[r]);
    qcur     = qc[r];
    conflict = any_h && (any_x || (qcur != '0) || mode);
    has_free = 1'b0;
    free_s   = '0;
    for (int s = HP - 1; s >= 0; s--) begin
      if (!hv[r][s]) begin
        has_free = 1'b1;
        free_s   = SW'(s);
      end
    end
    slot_w  = found ? fslot : free_s;
    hit     = pend && hv[r][ps] && (h_rdata == t);
    h_re    = (st == S_SCAN) && !hit && (sc != SCW'(HP));
    h_raddr = HAW'(HAW'(r) * HAW'(HP) + HAW'(sc));
    h_waddr = HAW'(HAW'(r) * HAW'(HP) + HAW'(slot_w));
    h_we    = (st == S_APPLY) && (act == selt_pkg::ACT_ACQUIRE) && (found || has_free);
  end

  always_comb begin
    qbase   = QAW'(QAW'(r) * QAW'(QD));
    q_we    = 1'b0;
    q_waddr = QAW'(qbase + QAW'(qcur));
    q_wdata = t;
    q_re    = 1'b0;
    q_raddr = QAW'(qbase + QAW'(qi));
    case (st)
      S_ACQ: begin
        q_we = conflict && (qcur < QW'(QD));
      end
      S_WD: begin
        q_we    = qpend && (q_rdata != t);
        q_waddr = QAW'(qbase + QAW'(qn));
        q_wdata = q_rdata;
        q_re    = qi < qcur;
      end
      S_APPLY: begin
        q_re    = (act != selt_pkg::ACT_ACQUIRE) && found && (qcur != '0);
        q_raddr = qbase;
      end
      default: begin
        q_we = 1'b0;
      end
    endcase
  end

  selt_ram #(.WIDTH(TB), .DEPTH(HD)) u_hold_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (t),
    .re    (h_re),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  selt_ram #(.WIDTH(TB), .DEPTH(QDP)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .re    (q_re),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      for (int i = 0; i < LR; i++) begin
        hv[i] <= '0;
        qc[i] <= '0;
      end
    end else begin
      case (st)
        S_IDLE: begin
          if (in_valid) begin
            act    <= in_data.action;
            t      <= t_in;
            mode   <= in_data.lock_mode;
            e_res  <= in_data.res_id;
            e_nv   <= 1'b0;
            e_last <= 1'b1;
            sc     <= '0;
            pend   <= 1'b0;
            found  <= 1'b0;
            qi     <= '0;
            qn     <= '0;
            qpend  <= 1'b0;
            wfound <= 1'b0;
            if (in_data.action == selt_pkg::ACT_RELEASE_ALL) begin
              r      <= '0;
              e_last <= 1'b0;
              st     <= S_SCAN;
            end else if (!loc) begin
              e_status <= selt_pkg::ST_NOT_LOCAL;
              st       <= S_EMIT;
            end else begin
              r <= r_in;
              case (in_data.action)
                selt_pkg::ACT_ACQUIRE: st <= S_ACQ;
                selt_pkg::ACT_RELEASE: st <= S_SCAN;
                default:               st <= S_WD;
              endcase
            end
          end
        end
        S_ACQ: begin
          if (conflict) begin
            if (qcur >= QW'(QD)) begin
              e_status <= selt_pkg::ST_QUEUE_FULL;
            end else begin
              qc[r]    <= QW'(qcur + 1'b1);
              e_status <= selt_pkg::ST_BLOCKED;
            end
            st <= S_EMIT;
          end else begin
            st <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            found <= 1'b1;
            fslot <= ps;
            pend  <= 1'b0;
            st    <= S_APPLY;
          end else if (sc == SCW'(HP)) begin
            pend <= 1'b0;
            st   <= S_APPLY;
          end else begin
            ps   <= sc[SW-1:0];
            sc   <= SCW'(sc + 1'b1);
            pend <= 1'b1;
          end
        end
        S_APPLY: begin
          if (act == selt_pkg::ACT_ACQUIRE) begin
            if (found || has_free) begin
              hv[r][slot_w] <= 1'b1;
              hm[r][slot_w] <= mode;
              e_status      <= selt_pkg::ST_GRANTED;
            end else begin
              e_status <= selt_pkg::ST_HOLD_FULL;
            end
            st <= S_EMIT;
          end else if (found) begin
            hv[r][fslot] <= 1'b0;
            hm[r][fslot] <= 1'b0;
            e_status     <= selt_pkg::ST_RELEASED;
            e_nv         <= qcur != '0;
            if (act == selt_pkg::ACT_RELEASE_ALL) begin
              e_res <= 16'(cfg.base + 16'(r));
            end
            st <= S_EMIT;
          end else if (act == selt_pkg::ACT_RELEASE_ALL) begin
            st <= S_NEXT;
          end else begin
            e_status <= selt_pkg::ST_NOT_HOLDER;
            st       <= S_EMIT;
          end
        end
        S_WD: begin
          if (qpend && (q_rdata == t)) begin
            wfound <= 1'b1;
          end else if (qpend) begin
            qn <= QW'(qn + 1'b1);
          end
          if (qi < qcur) begin
            qi    <= QW'(qi + 1'b1);
            qpend <= 1'b1;
          end else begin
            qpend <= 1'b0;
            if (!qpend) begin
              qc[r]    <= qn;
              e_status <= wfound ? selt_pkg::ST_WITHDRAWN : selt_pkg::ST_NOT_WAITING;
              st       <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (o_ready) begin
            if ((act == selt_pkg::ACT_RELEASE_ALL) && !e_last) begin
              st <= S_NEXT;
            end else begin
              st <= S_IDLE;
            end
          end
        end
        S_NEXT: begin
          e_nv <= 1'b0;
          if (r == RW'(LR - 1)) begin
            e_status <= selt_pkg::ST_DONE;
            e_res    <= 16'd0;
            e_last   <= 1'b1;
            st       <= S_EMIT;
          end else begin
            r     <= RW'(r + 1'b1);
            sc    <= '0;
            pend  <= 1'b0;
            found <= 1'b0;
            st    <= S_SCAN;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (st == S_IDLE);
  assign o_valid  = (st == S_EMIT);

  always_comb begin
    o_data.status       = e_status;
    o_data.res_id_out   = e_res;
    o_data.notify_valid = e_nv;
    o_data.notify_trans = e_nv ? 16'(q_rdata) : 16'd0;
    o_data.last         = e_last;
  end
endmodule

// ===== hdl/shared_exclusive_lock_table.sv =====
// Acquire (unless queued) and release scan the resource's holders, withdraw scans its queue,
// and release all scans every local resource; a not-local request skips the scans. Release
// all gives one result per resource released, then a done result; one item at a time. The
// result sits in an output register, so the next item is taken while it waits. Reset
// (synchronous): holder valid bits and queue counts cleared at once, node 1 with 32 ids per
// node; queue storage is not cleared.
module shared_exclusive_lock_table #(
  parameter int LOCAL_RESOURCES      = selt_pkg::LOCAL_RESOURCES_DEF,
  parameter int HOLDERS_PER_RESOURCE = selt_pkg::HOLDERS_PER_RESOURCE_DEF,
  parameter int QUEUE_DEPTH          = selt_pkg::QUEUE_DEPTH_DEF,
  parameter int TRANS_ID_BITS        = selt_pkg::TRANS_ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  selt_chan_if.sink   req,
  selt_chan_if.source rsp
);
  logic [7:0]     node_id;
  logic [5:0]     rpn;
  logic [15:0]    base;
  selt_pkg::cfg_t cfg;
  logic           e_valid;
  logic           e_ready;
  selt_pkg::rsp_t e_data;
  logic           out_valid;
  selt_pkg::rsp_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id <= 8'd1;
      rpn     <= 6'd32;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          selt_pkg::CFG_NODE_ID:      node_id <= cfg_data;
          selt_pkg::CFG_RES_PER_NODE: rpn     <= cfg_data[5:0];
          default:                    node_id <= node_id;
        endcase
      end
    end
  end

  always_comb begin
    base = 16'((16'(node_id) - 16'd1) * 16'(rpn) + 16'd1);
  end

  assign cfg = '{node_id: node_id, rpn: rpn, base: base};

  selt_engine #(
    .LR (LOCAL_RESOURCES),
    .HP (HOLDERS_PER_RESOURCE),
    .QD (QUEUE_DEPTH),
    .TB (TRANS_ID_BITS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_data  (req.data),
    .o_valid  (e_valid),
    .o_ready  (e_ready),
    .o_data   (e_data)
  );

  assign e_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (e_valid && e_ready) begin
        out_valid <= 1'b1;
        out_data  <= e_data;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

`include "shared_exclusive_lock_table_assert.svh"

  `SELT_ASSERT_IMP(a_notify_zero, rsp.valid && !rsp.data.notify_valid, rsp.data.notify_trans == 16'd0, "notify_trans set without notify_valid")
  `SELT_ASSERT_IMP(a_done_last, rsp.valid && (rsp.data.status == selt_pkg::ST_DONE), rsp.data.last, "done result without last")
  `SELT_ASSERT_IMP(a_mid_released, rsp.valid && !rsp.data.last, rsp.data.status == selt_pkg::ST_RELEASED, "non-final result is not a release")
  `SELT_ASSERT_NXT(a_one_at_a_time, req.valid && req.ready, !req.ready, "transaction accepted while busy")
endmodule

// ===== tb/shared_exclusive_lock_table_checker.sv =====
module shared_exclusive_lock_table_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  selt_chan_if       req,
  selt_chan_if       rsp,
  output int         pending,
  output int         errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NRES  = selt_pkg::LOCAL_RESOURCES_DEF;
  localparam int NHOLD = selt_pkg::HOLDERS_PER_RESOURCE_DEF;
  localparam int QD    = selt_pkg::QUEUE_DEPTH_DEF;

  logic           hold_v  [NRES][NHOLD];
  logic           hold_x  [NRES][NHOLD];
  logic [15:0]    hold_t  [NRES][NHOLD];
  logic [15:0]    waiters [NRES][QD];
  int             wait_n  [NRES];
  logic [7:0]     node_id;
  logic [5:0]     rpn;
  selt_pkg::rsp_t lock_results[$];

  initial begin
    errors  = 0;
    pending = 0;
    node_id = 8'd1;
    rpn     = 6'd32;
    for (int r = 0; r < NRES; r++) begin
      wait_n[r] = 0;
      for (int s = 0; s < NHOLD; s++) begin
        hold_v[r][s] = 1'b0;
        hold_x[r][s] = 1'b0;
        hold_t[r][s] = '0;
      end
    end
  end

  function automatic int unsigned node_base();
    int unsigned nd, rp;
    nd = node_id;
    rp = rpn;
    return (nd - 1) * rp + 1;
  endfunction

  function automatic bit to_local(input logic [15:0] res, output int idx);
    int unsigned b, d;
    idx = 0;
    if (res == 0 || node_id == 0 || rpn == 0) return 1'b0;
    b = node_base();
    if (res < b) return 1'b0;
    d = res - b;
    if (d >= rpn || d >= NRES) return 1'b0;
    idx = d;
    return 1'b1;
  endfunction

  function automatic int holder_slot(input int r, input logic [15:0] t);
    for (int s = 0; s < NHOLD; s++)
      if (hold_v[r][s] && hold_t[r][s] == t) return s;
    return -1;
  endfunction

  function automatic bit drop_holder(input int r, input logic [15:0] t,
                                     output bit nv, output logic [15:0] head);
    int s;
    s = holder_slot(r, t);
    nv = 1'b0;
    head = '0;
    if (s < 0) return 1'b0;
    hold_v[r][s] = 1'b0;
    hold_x[r][s] = 1'b0;
    hold_t[r][s] = '0;
    if (wait_n[r] != 0) begin
      nv = 1'b1;
      head = waiters[r][0];
    end
    return 1'b1;
  endfunction

  function automatic logic [3:0] take_lock(input int r, input logic [15:0] t, input logic x);
    bit any, clash;
    int slot;
    any = 1'b0;
    clash = 1'b0;
    for (int s = 0; s < NHOLD; s++)
      if (hold_v[r][s]) begin
        any = 1'b1;
        if (hold_x[r][s]) clash = 1'b1;
      end
    if (any && (wait_n[r] != 0 || x)) clash = 1'b1;
    if (!any) clash = 1'b0;
    if (clash) begin
      if (wait_n[r] >= QD) return selt_pkg::ST_QUEUE_FULL;
      waiters[r][wait_n[r]] = t;
      wait_n[r]++;
      return selt_pkg::ST_BLOCKED;
    end
    slot = holder_slot(r, t);
    if (slot < 0) begin
      for (int s = 0; s < NHOLD; s++)
        if (!hold_v[r][s]) begin
          slot = s;
          break;
        end
      if (slot < 0) return selt_pkg::ST_HOLD_FULL;
    end
    hold_v[r][slot] = 1'b1;
    hold_t[r][slot] = t;
    hold_x[r][slot] = x;
    return selt_pkg::ST_GRANTED;
  endfunction

  function automatic bit unqueue(input int r, input logic [15:0] t);
    int n;
    bit found;
    n = 0;
    found = 1'b0;
    for (int i = 0; i < wait_n[r]; i++) begin
      if (waiters[r][i] == t) found = 1'b1;
      else begin
        waiters[r][n] = waiters[r][i];
        n++;
      end
    end
    wait_n[r] = n;
    return found;
  endfunction

  function automatic selt_pkg::rsp_t mk(input logic [3:0] st, input logic [15:0] res,
                                        input bit nv, input logic [15:0] nt, input bit lst);
    selt_pkg::rsp_t o;
    o.status = st;
    o.res_id_out = res;
    o.notify_valid = nv;
    o.notify_trans = nv ? nt : 16'd0;
    o.last = lst;
    return o;
  endfunction

  function automatic void add_result(input selt_pkg::rsp_t o);
    lock_results = {lock_results, o};
  endfunction

  task automatic predict_lock(input selt_pkg::req_t q);
    int r;
    bit nv;
    logic [15:0] head;
    int unsigned b;
    if (q.action == selt_pkg::ACT_RELEASE_ALL) begin
      b = node_base();
      for (int i = 0; i < NRES; i++)
        if (drop_holder(i, q.trans_id, nv, head))
          add_result(mk(selt_pkg::ST_RELEASED, 16'(b + i), nv, head, 1'b0));
      add_result(mk(selt_pkg::ST_DONE, 16'd0, 1'b0, 16'd0, 1'b1));
    end else if (!to_local(q.res_id, r)) begin
      add_result(mk(selt_pkg::ST_NOT_LOCAL, q.res_id, 1'b0, 16'd0, 1'b1));
    end else if (q.action == selt_pkg::ACT_ACQUIRE) begin
      add_result(mk(take_lock(r, q.trans_id, q.lock_mode), q.res_id, 1'b0, 16'd0, 1'b1));
    end else if (q.action == selt_pkg::ACT_RELEASE) begin
      if (drop_holder(r, q.trans_id, nv, head))
        add_result(mk(selt_pkg::ST_RELEASED, q.res_id, nv, head, 1'b1));
      else
        add_result(mk(selt_pkg::ST_NOT_HOLDER, q.res_id, 1'b0, 16'd0, 1'b1));
    end else begin
      add_result(mk(unqueue(r, q.trans_id) ? selt_pkg::ST_WITHDRAWN : selt_pkg::ST_NOT_WAITING,
                    q.res_id, 1'b0, 16'd0, 1'b1));
    end
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    selt_pkg::rsp_t got, want;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == selt_pkg::CFG_NODE_ID) node_id = cfg_data;
        else rpn = cfg_data[5:0];
      end
      if (req.valid && req.ready) predict_lock(req.data);
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        if (lock_results.size() == 0) begin
          report("unexpected transaction", got.res_id_out, 16'd0);
        end else begin
          want = lock_results.pop_front();
          if (got.status !== want.status)
            report("status", 16'(got.status), 16'(want.status));
          if (got.res_id_out !== want.res_id_out)
            report("res_id_out", got.res_id_out, want.res_id_out);
          if (got.notify_valid !== want.notify_valid)
            report("notify_valid", 16'(got.notify_valid), 16'(want.notify_valid));
          if (got.notify_trans !== want.notify_trans)
            report("notify_trans", got.notify_trans, want.notify_trans);
          if (got.last !== want.last) report("last", 16'(got.last), 16'(want.last));
        end
      end
      pending = lock_results.size();
    end
  end
endmodule

// ===== tb/shared_exclusive_lock_table_tb.sv =====
module shared_exclusive_lock_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;
  int         pending;
  int         errors;
  int         cycles;
  bit         calm;
  int         cur_node;
  int         cur_rpn;

  selt_chan_if #(.T(selt_pkg::req_t)) req_ch ();
  selt_chan_if #(.T(selt_pkg::rsp_t)) rsp_ch ();

  shared_exclusive_lock_table u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  shared_exclusive_lock_table_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_lock(input logic [1:0] act, input logic [15:0] t, input logic [15:0] res,
                           input logic x);
    int gap;
    selt_pkg::req_t q;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    q.action = act;
    q.trans_id = t;
    q.res_id = res;
    q.lock_mode = x;
    req_ch.valid <= 1'b1;
    req_ch.data <= q;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_regs(input logic [7:0] nd, input logic [7:0] rp);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= selt_pkg::CFG_NODE_ID;
    cfg_data <= nd;
    @(negedge clk);
    cfg_index <= selt_pkg::CFG_RES_PER_NODE;
    cfg_data <= rp;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_node = nd;
    cur_rpn = rp & 8'h3f;
  endtask

  function automatic logic [15:0] pick_res();
    int unsigned b, span, p;
    b = (cur_node - 1) * cur_rpn + 1;
    span = (cur_rpn == 0) ? 1 : ((cur_rpn > 32) ? 32 : cur_rpn);
    p = $urandom_range(0, 99);
    if (p < 55) return 16'(b + $urandom_range(0, (span > 5 ? 5 : span) - 1));
    if (p < 75) return 16'(b + $urandom_range(0, span - 1));
    if (p < 82) return 16'($urandom);
    if (p < 86) return 16'd0;
    if (p < 90) return 16'hffff;
    if (p < 95) return 16'($urandom_range(0, 1) ? b - 1 : b + cur_rpn);
    return 16'(b + $urandom_range(0, 63));
  endfunction

  function automatic logic [15:0] pick_trans();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 85) return 16'($urandom_range(0, 9));
    if (p < 92) return 16'hffff;
    return 16'($urandom);
  endfunction

  task automatic random_phase(input int n);
    int unsigned p;
    logic [1:0] act;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      act = (p < 45) ? selt_pkg::ACT_ACQUIRE : (p < 75) ? selt_pkg::ACT_RELEASE :
            (p < 90) ? selt_pkg::ACT_WITHDRAW : selt_pkg::ACT_RELEASE_ALL;
      send_lock(act, pick_trans(), pick_res(), 1'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = selt_pkg::CFG_NODE_ID;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    calm = 1'b0;
    cur_node = 1;
    cur_rpn = 32;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_lock(selt_pkg::ACT_ACQUIRE, 16'd1, 16'd1, 1'b0);
    send_lock(selt_pkg::ACT_ACQUIRE, 16'd2, 16'd1, 1'b0);
    send_lock(selt_pkg::ACT_ACQUIRE, 16'd3, 16'd1, 1'b1);
    send_lock(selt_pkg::ACT_ACQUIRE, 16'd3, 16'd1, 1'b1);
    send_lock(selt_pkg::ACT_ACQUIRE, 16'd1, 16'd1, 1'b1);
    send_lock(selt_pkg::ACT_ACQUIRE, 16'd4, 16'd1, 1'b0);
    send_lock(selt_pkg::ACT_WITHDRAW, 16'd1, 16'd1, 1'b0);
    send_lock(selt_pkg::ACT_WITHDRAW, 16'd9, 16'd1, 1'b0);
    send_lock(selt_pkg::ACT_RELEASE, 16'd2, 16'd1, 1'b0);
    send_lock(selt_pkg::ACT_RELEASE, 16'd2, 16'd1, 1'b1);
    send_lock(selt_pkg::ACT_ACQUIRE, 16'd5, 16'd0, 1'b0);
    send_lock(selt_pkg::ACT_ACQUIRE, 16'd5, 16'd33, 1'b1);
    send_lock(selt_pkg::ACT_RELEASE, 16'hffff, 16'hffff, 1'b1);
    for (int i = 0; i < 9; i++) send_lock(selt_pkg::ACT_ACQUIRE, 16'(10 + i), 16'd32, 1'b0);
    for (int i = 0; i < 8; i++) send_lock(selt_pkg::ACT_ACQUIRE, 16'(20 + i), 16'd1, 1'b1);
    send_lock(selt_pkg::ACT_WITHDRAW, 16'd3, 16'd1, 1'b0);
    send_lock(selt_pkg::ACT_RELEASE_ALL, 16'd1, 16'd0, 1'b0);

    random_phase(25);
    calm = 1'b1;
    set_regs(8'd255, 8'd63);
    random_phase(20);
    calm = 1'b0;
    set_regs(8'd2, 8'd5);
    random_phase(25);
    set_regs(8'd1, 8'd1);
    random_phase(20);
    set_regs(8'd0, 8'd32);
    random_phase(20);
    set_regs(8'd3, 8'd64);
    random_phase(15);
    calm = 1'b1;
    set_regs(8'd7, 8'd16);
    random_phase(25);
    calm = 1'b0;
    set_regs(8'd1, 8'd32);
    random_phase(50);

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/selt_pkg.sv
hdl/selt_chan_if.sv
hdl/selt_ram.sv
hdl/selt_engine.sv
hdl/shared_exclusive_lock_table.sv
tb/shared_exclusive_lock_table_checker.sv
tb/shared_exclusive_lock_table_tb.sv
